[design/bcv3p_pkg.sv]
`default_nettype none
package bcv3p_pkg;

    // field and word sizes
    localparam int COORD_W       = 16;
    localparam int CAP_W         = 21;
    localparam int PEND_W        = 7;
    localparam int NUM_LANES     = 3;
    localparam int MAX_RESULTS   = 8;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int INT_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 21'd1048576;

    // command codes
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // input word
    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_full;
    } t_out_word;

    // bytes of one item handed from the merge stage to the output buffer
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        full;
    } t_load;

endpackage
`default_nettype wire

[design/bcv3p_lane.sv]
`default_nettype none
module bcv3p_lane #(
    parameter int INT_BITS  = bcv3p_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS = bcv3p_pkg::FRAC_BITS_DEF,
    parameter int LANE_W    = 3 + INT_BITS + FRAC_BITS,
    parameter int LEN_W     = $clog2(LANE_W + 1)
) (
    input  wire logic signed [bcv3p_pkg::COORD_W-1:0] i_coord,
    output logic [LANE_W-1:0]                         o_field,
    output logic [LEN_W-1:0]                          o_len
);

    localparam int CW = bcv3p_pkg::COORD_W;

    logic [CW-1:0]        mag;
    logic [CW-1:0]        ival_w;
    logic                 over;
    logic                 sgn;
    logic                 hi;
    logic                 hf;
    logic [INT_BITS-1:0]  ival;
    logic [FRAC_BITS-1:0] fval;

    // magnitude split into integer and fraction, saturating on overflow
    always_comb begin
        sgn    = i_coord[CW-1];
        mag    = sgn ? CW'(-i_coord) : CW'(i_coord);
        ival_w = mag >> FRAC_BITS;
        over   = (ival_w >> INT_BITS) != '0;
        ival   = over ? '1 : ival_w[INT_BITS-1:0];
        fval   = over ? '1 : mag[FRAC_BITS-1:0];
        hi     = ival != '0;
        hf     = fval != '0;
    end

    // field bits lsb first: has-int, has-frac, sign, integer, fraction
    always_comb begin
        o_field = LANE_W'({sgn, hf, hi});
        if (hi) begin
            o_field = o_field | (LANE_W'(ival) << 3);
        end
        if (hf) begin
            o_field = o_field | (LANE_W'(fval) << (hi ? 3 + INT_BITS : 3));
        end
        o_len = LEN_W'(3 + (hi ? INT_BITS : 0) + (hf ? FRAC_BITS : 0));
        if (i_coord == '0) begin
            o_field = '0;
            o_len   = '0;
        end
    end

endmodule
`default_nettype wire

[design/bcv3p_merge.sv]
`default_nettype none
module bcv3p_merge #(
    parameter int INT_BITS  = bcv3p_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS = bcv3p_pkg::FRAC_BITS_DEF,
    parameter int LANE_W    = 3 + INT_BITS + FRAC_BITS,
    parameter int LEN_W     = $clog2(LANE_W + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr,
    input  wire logic [bcv3p_pkg::CAP_W-1:0]   i_cfg_data,
    input  wire logic                          i_take,
    input  wire logic                          i_cmd,
    input  wire logic [LANE_W-1:0]             i_field [bcv3p_pkg::NUM_LANES],
    input  wire logic [LEN_W-1:0]              i_len [bcv3p_pkg::NUM_LANES],
    output logic                               o_load_valid,
    output bcv3p_pkg::t_load                   o_load
);

    localparam int CAP_W  = bcv3p_pkg::CAP_W;
    localparam int PEND_W = bcv3p_pkg::PEND_W;
    localparam int MAXR   = bcv3p_pkg::MAX_RESULTS;
    localparam int CNT_W  = bcv3p_pkg::CNT_W;
    localparam int ACC_W  = PEND_W + bcv3p_pkg::NUM_LANES * (1 + LANE_W);
    localparam int ACC_M  = (ACC_W > 8 * MAXR) ? ACC_W : 8 * MAXR;
    localparam int ACC_V  = 8 * ((ACC_M + 7) / 8);
    localparam int TB_W   = $clog2(ACC_W + 1);
    localparam int NB_W   = $clog2(ACC_W / 8 + 1);

    logic [CAP_W-1:0]  r_cap;
    logic [PEND_W-1:0] r_pend;
    logic [2:0]        r_pc;
    logic [CAP_W-1:0]  r_be;
    logic              r_full;

    logic [PEND_W-1:0] n_pend;
    logic [2:0]        n_pc;
    logic [CAP_W-1:0]  n_be;
    logic              n_full;

    logic [TB_W-1:0]   off1;
    logic [TB_W-1:0]   off2;
    logic [TB_W-1:0]   off3;
    logic [TB_W-1:0]   tot;
    logic [2:0]        flags;
    logic [ACC_V-1:0]  acc;
    logic [ACC_V-1:0]  rest;
    logic [NB_W-1:0]   nb;
    logic [NB_W-1:0]   emit;
    logic [CAP_W-1:0]  avail;
    logic              blocked;
    logic              fills;
    logic              drop;

    // lane fields placed after the presence flags and the pending bits
    always_comb begin
        flags = {i_len[2] != '0, i_len[1] != '0, i_len[0] != '0};
        off1  = TB_W'(r_pc) + TB_W'(3);
        off2  = off1 + TB_W'(i_len[0]);
        off3  = off2 + TB_W'(i_len[1]);
        tot   = off3 + TB_W'(i_len[2]);
        acc   = ACC_V'(r_pend)
              | (ACC_V'(flags) << r_pc)
              | (ACC_V'(i_field[0]) << off1)
              | (ACC_V'(i_field[1]) << off2)
              | (ACC_V'(i_field[2]) << off3);
        nb    = NB_W'(tot >> 3);
        rest  = acc >> {nb, 3'b000};
    end

    // capacity check
    always_comb begin
        blocked = r_full || (r_be >= r_cap);
        avail   = r_cap - r_be;
        fills   = CAP_W'(nb) >= avail;
        drop    = (CAP_W'(nb) > avail) || (tot[2:0] != 3'd0);
    end

    // next state and bytes of this word
    always_comb begin
        n_pend       = r_pend;
        n_pc         = r_pc;
        n_full       = r_full;
        emit         = '0;
        o_load.bytes = acc[8*MAXR-1:0];
        if (i_cmd == bcv3p_pkg::CMD_FLUSH) begin
            o_load.bytes = (8 * MAXR)'(r_pend);
            if (r_pc != 3'd0) begin
                n_pend = '0;
                n_pc   = 3'd0;
                if (blocked) begin
                    n_full = 1'b1;
                end else begin
                    emit   = NB_W'(1);
                    n_full = (r_be + CAP_W'(1)) >= r_cap;
                end
            end
        end else begin
            if (blocked) begin
                n_full = 1'b1;
                n_pend = '0;
                n_pc   = 3'd0;
            end else if (fills) begin
                emit   = NB_W'(avail);
                n_full = drop;
                n_pend = '0;
                n_pc   = 3'd0;
            end else begin
                emit   = nb;
                n_pend = rest[PEND_W-1:0];
                n_pc   = tot[2:0];
            end
        end
        n_be         = r_be + CAP_W'(emit);
        o_load.count = (32'(emit) > MAXR) ? CNT_W'(MAXR) : CNT_W'(emit);
        o_load.full  = n_full;
        o_load_valid = i_take && (emit != '0);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= bcv3p_pkg::CAP_RESET;
            r_pend <= '0;
            r_pc   <= 3'd0;
            r_be   <= '0;
            r_full <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_cap <= i_cfg_data;
            end
            if (i_take) begin
                r_pend <= n_pend;
                r_pc   <= n_pc;
                r_be   <= n_be;
                r_full <= n_full;
            end
        end
    end

endmodule
`default_nettype wire

[design/bcv3p_obuf.sv]
`default_nettype none
module bcv3p_obuf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load_valid,
    input  wire bcv3p_pkg::t_load     i_load,
    output logic                      o_can_load,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output bcv3p_pkg::t_out_word      o_data
);

    localparam int MAXR  = bcv3p_pkg::MAX_RESULTS;
    localparam int CNT_W = bcv3p_pkg::CNT_W;

    logic [MAXR-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]     r_left;
    logic                 r_full;
    logic                 out_acc;

    // output word is always the head byte
    always_comb begin
        o_valid            = r_left != '0;
        out_acc            = (r_left != '0) && i_ready;
        o_can_load         = (r_left == '0) || ((r_left == CNT_W'(1)) && i_ready);
        o_data.out_byte    = r_bytes[0];
        o_data.last_of_run = r_left == CNT_W'(1);
        o_data.stream_full = r_full;
    end

    // byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load_valid) begin
            r_left <= i_load.count;
        end else if (out_acc) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    // byte shift line
    always_ff @(posedge i_clk) begin
        if (i_load_valid) begin
            r_bytes <= i_load.bytes;
            r_full  <= i_load.full;
        end else if (out_acc) begin
            r_bytes <= r_bytes >> 8;
        end
    end

endmodule
`default_nettype wire

[design/bit_coord_vec3_packer.sv]
`default_nettype none
// Packs three signed coordinates (units of 2^-FRAC_BITS) into an lsb-first
// byte stream. Each encode word writes three presence flags and, per present
// coordinate, has-int/has-frac/sign bits plus the INT_BITS integer and
// FRAC_BITS fraction bits of each nonzero part; a flush word pads the pending
// bits to a byte. Three coordinate lanes work in parallel in the first
// stage, a merge stage joins their fields with the up to 7 pending bits and
// applies the capacity limit, and an 8-byte buffer hands out one byte per
// cycle while the receiver is ready. A word is taken as the last byte of the
// previous one leaves the single byte-wide output port. The user must write
// the capacity register through the cfg port only while the block is idle;
// the block does not enforce this, and the register resets to 1048576 bytes.
module bit_coord_vec3_packer #(
    parameter int INT_BITS  = bcv3p_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS = bcv3p_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire bcv3p_pkg::t_in_word          i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output bcv3p_pkg::t_out_word              o_out_data,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [bcv3p_pkg::CAP_W-1:0]  i_cfg_data
);

    localparam int LANE_W = 3 + INT_BITS + FRAC_BITS;
    localparam int LEN_W  = $clog2(LANE_W + 1);
    localparam int NL     = bcv3p_pkg::NUM_LANES;

    logic signed [bcv3p_pkg::COORD_W-1:0] coords [NL];
    logic [LANE_W-1:0] lane_field [NL];
    logic [LEN_W-1:0]  lane_len [NL];

    logic              r_s1_valid;
    logic              r_s1_cmd;
    logic [LANE_W-1:0] r_s1_field [NL];
    logic [LEN_W-1:0]  r_s1_len [NL];

    logic              can_load;
    logic              take;
    logic              load_valid;
    bcv3p_pkg::t_load  load;

    assign coords[0]   = i_in_data.coord_x;
    assign coords[1]   = i_in_data.coord_y;
    assign coords[2]   = i_in_data.coord_z;
    assign o_cfg_ready = 1'b1;

    // coordinate lanes
    for (genvar g = 0; g < NL; g++) begin : g_lane
        bcv3p_lane #(
            .INT_BITS  (INT_BITS),
            .FRAC_BITS (FRAC_BITS),
            .LANE_W    (LANE_W),
            .LEN_W     (LEN_W)
        ) u_lane (
            .i_coord (coords[g]),
            .o_field (lane_field[g]),
            .o_len   (lane_len[g])
        );
    end

    // stage handshake
    assign take       = r_s1_valid && can_load;
    assign o_in_ready = !r_s1_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // lane results register
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_cmd   <= i_in_data.cmd;
            r_s1_field <= lane_field;
            r_s1_len   <= lane_len;
        end
    end

    bcv3p_merge #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS),
        .LANE_W    (LANE_W),
        .LEN_W     (LEN_W)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_take       (take),
        .i_cmd        (r_s1_cmd),
        .i_field      (r_s1_field),
        .i_len        (r_s1_len),
        .o_load_valid (load_valid),
        .o_load       (load)
    );

    bcv3p_obuf u_obuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (load_valid),
        .i_load       (load),
        .o_can_load   (can_load),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (o_out_data)
    );

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

    // clock, reset and block ports
    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             in_valid    = 1'b0;
    bcv3p_pkg::t_in_word              in_data     = '0;
    logic                             out_ready   = 1'b0;
    logic                             cfg_valid   = 1'b0;
    logic [bcv3p_pkg::CAP_W-1:0]      cfg_data    = '0;
    logic                             in_ready;
    logic                             out_valid;
    bcv3p_pkg::t_out_word             out_data;
    logic                             cfg_ready;

    // idling knobs, in percent
    int                               in_idle_pct   = 0;
    int                               out_stall_pct = 0;
    int                               errors        = 0;

    // shadow state of the packer
    logic [7:0]                       acc_bits   = '0;
    int                               acc_cnt    = 0;
    logic [bcv3p_pkg::CAP_W-1:0]      sent_bytes = '0;
    logic                             full_st    = 1'b0;
    logic [bcv3p_pkg::CAP_W-1:0]      cap_reg    = bcv3p_pkg::CAP_RESET;
    logic [7:0]                       run_bytes[$];
    bcv3p_pkg::t_out_word             exp_words[$];

    bit_coord_vec3_packer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // 2 ns clock
    initial begin
        forever #1 clk = ~clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("** bit_coord_vec3_packer: FAILED **");
        $finish;
    end

    // receiver stalls
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // one bit into the stream; dropped once the buffer is full
    function automatic void put_bit(logic b);
        if (full_st || sent_bytes >= cap_reg) begin
            full_st  = 1'b1;
            acc_bits = '0;
            acc_cnt  = 0;
            return;
        end
        acc_bits[acc_cnt] = b;
        acc_cnt++;
        if (acc_cnt == 8) begin
            run_bytes.push_back(acc_bits);
            sent_bytes = sent_bytes + 1'b1;
            acc_bits   = '0;
            acc_cnt    = 0;
        end
    endfunction

    // lsb first field
    function automatic void put_field(int val, int nbits);
        for (int i = 0; i < nbits; i++) begin
            put_bit(((val >> i) & 1) != 0);
        end
    endfunction

    // has-int, has-frac, sign, then integer and fraction parts
    function automatic void put_coord(logic signed [bcv3p_pkg::COORD_W-1:0] c);
        int mag;
        int ival;
        int fval;
        mag  = (c < 0) ? -int'(c) : int'(c);
        ival = mag >> bcv3p_pkg::FRAC_BITS_DEF;
        fval = mag & ((1 << bcv3p_pkg::FRAC_BITS_DEF) - 1);
        // integer part too wide saturates both parts
        if (ival > (1 << bcv3p_pkg::INT_BITS_DEF) - 1) begin
            ival = (1 << bcv3p_pkg::INT_BITS_DEF) - 1;
            fval = (1 << bcv3p_pkg::FRAC_BITS_DEF) - 1;
        end
        put_bit(ival != 0);
        put_bit(fval != 0);
        put_bit(c < 0);
        if (ival != 0) put_field(ival, bcv3p_pkg::INT_BITS_DEF);
        if (fval != 0) put_field(fval, bcv3p_pkg::FRAC_BITS_DEF);
    endfunction

    // pad pending bits to a byte
    function automatic void flush_pending();
        if (acc_cnt == 0) return;
        if (full_st || sent_bytes >= cap_reg) begin
            full_st = 1'b1;
        end else begin
            run_bytes.push_back(acc_bits);
            sent_bytes = sent_bytes + 1'b1;
            if (sent_bytes >= cap_reg) full_st = 1'b1;
        end
        acc_bits = '0;
        acc_cnt  = 0;
    endfunction

    // expected bytes for one accepted word
    function automatic void pack_word(bcv3p_pkg::t_in_word w);
        bcv3p_pkg::t_out_word e;
        run_bytes.delete();
        if (w.cmd == bcv3p_pkg::CMD_FLUSH) begin
            flush_pending();
        end else begin
            put_bit(w.coord_x != 0);
            put_bit(w.coord_y != 0);
            put_bit(w.coord_z != 0);
            if (w.coord_x != 0) put_coord(w.coord_x);
            if (w.coord_y != 0) put_coord(w.coord_y);
            if (w.coord_z != 0) put_coord(w.coord_z);
        end
        for (int k = 0; k < run_bytes.size() && k < bcv3p_pkg::MAX_RESULTS; k++) begin
            e.out_byte    = run_bytes[k];
            e.last_of_run = (k == run_bytes.size() - 1);
            e.stream_full = full_st;
            exp_words.push_back(e);
        end
    endfunction

    // prediction on accepted inputs, checking of accepted outputs
    always @(posedge clk) begin
        bcv3p_pkg::t_out_word e;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) cap_reg = cfg_data;
            if (in_valid && in_ready) pack_word(in_data);
            if (out_valid && out_ready) begin
                if (exp_words.size() == 0) begin
                    $display("%0t: unexpected word: byte %02h last %0d full %0d", $time,
                             out_data.out_byte, out_data.last_of_run, out_data.stream_full);
                    errors++;
                end else begin
                    e = exp_words.pop_front();
                    if (out_data !== e) begin
                        $display({"%0t: mismatch: expected byte %02h last %0d full %0d,",
                                  " got byte %02h last %0d full %0d"},
                                 $time, e.out_byte, e.last_of_run, e.stream_full,
                                 out_data.out_byte, out_data.last_of_run,
                                 out_data.stream_full);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic bcv3p_pkg::t_in_word make_word(logic cmd, logic [15:0] x,
                                                      logic [15:0] y, logic [15:0] z);
        bcv3p_pkg::t_in_word w;
        w.cmd     = cmd;
        w.coord_x = x;
        w.coord_y = y;
        w.coord_z = z;
        return w;
    endfunction

    // coordinate mix: absent, fraction only, integer only, extremes, small negatives, anything
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return 16'($urandom_range(7));
            3:       return 16'($urandom_range(4095)) << 3;
            4: begin
                case ($urandom_range(2))
                    0:       return 16'sd32767;
                    1:       return -16'sd32767;
                    default: return 16'h8000;
                endcase
            end
            5:       return -16'($urandom_range(64, 1));
            default: return 16'($urandom);
        endcase
    endfunction

    // send one word, waiting for it to be taken
    task automatic send_word(input bcv3p_pkg::t_in_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_vec(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        send_word(make_word(bcv3p_pkg::CMD_ENCODE, x, y, z));
    endtask

    // flush; coordinates carry junk that must be ignored
    task automatic send_flush();
        send_word(make_word(bcv3p_pkg::CMD_FLUSH, 16'($urandom), 16'($urandom),
                            16'($urandom)));
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (exp_words.size() != 0);
    endtask

    // capacity write only while idle
    task automatic write_capacity(input logic [bcv3p_pkg::CAP_W-1:0] cap);
        in_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // field extremes and coordinate split cases
    task automatic test_coord_extremes();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        write_capacity(bcv3p_pkg::CAP_RESET);
        send_vec(16'd0, 16'd0, 16'd0);
        send_vec(16'd1, 16'd0, 16'd0);
        send_vec(16'd0, 16'd8, 16'd0);
        send_vec(16'd0, 16'd0, -16'sd1);
        send_vec(-16'sd8, 16'd7, -16'sd9);
        send_vec(16'sd32767, 16'sd32767, 16'sd32767);
        send_vec(-16'sd32767, -16'sd32767, -16'sd32767);
        // integer part too wide, saturates
        send_vec(16'h8000, 16'h8000, 16'h8000);
        send_vec(16'sd32767, 16'h8000, 16'd1);
        send_vec(16'h5555, 16'hAAAA, 16'h5555);
        send_vec(16'hAAAA, 16'h5555, 16'hAAAA);
    endtask

    // flush with and without pending bits
    task automatic test_flush();
        send_vec(16'd0, 16'd0, 16'd0);
        send_flush();
        send_flush();
        send_vec(16'd3, 16'd0, 16'd0);
        send_word(make_word(bcv3p_pkg::CMD_FLUSH, 16'hFFFF, 16'h0000, 16'hFFFF));
        send_word(make_word(bcv3p_pkg::CMD_FLUSH, 16'h0000, 16'hFFFF, 16'h0000));
        send_vec(16'd0, 16'd0, 16'd0);
    endtask

    // random words under one idling setting
    task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                      input int n_words, input bit hold_off);
        write_capacity(21'($urandom_range(bcv3p_pkg::CAP_RESET, 8192)));
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        for (int i = 0; i < n_words; i++) begin
            // let the output side run dry once mid-phase
            if (hold_off && i == n_words / 2) begin
                in_valid <= 1'b0;
                wait_drained();
            end
            if ($urandom_range(99) < 15) begin
                send_flush();
            end else begin
                send_vec(rand_coord(), rand_coord(), rand_coord());
            end
        end
        in_idle_pct = 0;
    endtask

    // buffer fills in the middle of a word, then everything is dropped
    task automatic test_capacity_limit();
        in_idle_pct   = 19;
        out_stall_pct = 19;
        send_flush();
        // byte count settles before the new capacity is taken from it
        in_valid <= 1'b0;
        wait_drained();
        write_capacity(sent_bytes + 1'b1);
        send_vec(16'd0, 16'd0, 16'd0);
        send_vec(16'd1, 16'd0, 16'd0);
        send_vec(16'sd32767, -16'sd32767, 16'h8000);
        send_flush();
        write_capacity('0);
        send_vec(16'd9, 16'd0, 16'd0);
        send_flush();
        write_capacity(21'd1);
        send_vec(-16'sd5, 16'd40, 16'd0);
        send_flush();
        write_capacity(bcv3p_pkg::CAP_RESET);
        send_vec(16'd1, 16'd1, 16'd1);
        send_flush();
    endtask

    // test sequence
    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_coord_extremes();
        test_flush();
        test_random_stream(0, 0, 38, 0);
        test_random_stream(58, 0, 38, 1);
        test_random_stream(0, 58, 38, 0);
        test_random_stream(19, 19, 38, 0);
        test_capacity_limit();
        in_valid <= 1'b0;
        wait_drained();
        repeat (30) @(posedge clk);
        if (errors == 0 && exp_words.size() == 0) begin
            $display("** bit_coord_vec3_packer: PASSED **");
        end else begin
            $display("** bit_coord_vec3_packer: FAILED **");
        end
        $finish;
    end

endmodule

[bit_coord_vec3_packer.f]
design/bcv3p_pkg.sv
design/bcv3p_lane.sv
design/bcv3p_merge.sv
design/bcv3p_obuf.sv
design/bit_coord_vec3_packer.sv
sim/tb.sv
